// ===== sv/tmqe_pkg.sv =====
// tmqe_pkg: shared constants, request/response codes and transaction types
// for the typed message queue engine; no dependencies
`default_nettype none
package tmqe_pkg;

  // default geometry
  localparam int NUM_QUEUES      = 8;
  localparam int SLOTS_PER_QUEUE = 16;
  localparam int MSG_BYTES       = 32;

  // input skid queue between front and back
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = 2;

  // request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_SEND  = 2'd2;
  localparam logic [1:0] REQ_RECV  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_ALLOC = 3'd1;
  localparam logic [2:0] ST_NO_SLOT  = 3'd2;
  localparam logic [2:0] ST_NO_MATCH = 3'd3;
  localparam logic [2:0] ST_NO_QUEUE = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         queue_id;
    logic signed [31:0] key;
    logic signed [31:0] msg_type;
    logic [7:0]         data_byte;
    logic               byte_present;
    logic               last_byte;
    logic [5:0]         recv_limit;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] result_queue;
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic [5:0] message_length;
    logic       last_result;
  } rsp_t;

endpackage
`default_nettype wire

// ===== sv/tmqe_if.sv =====
// tmqe_req_if / tmqe_rsp_if: valid/ready channels for request and response
// transactions; depends on tmqe_pkg
`default_nettype none
interface tmqe_req_if;
  logic            valid;
  logic            ready;
  tmqe_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tmqe_rsp_if;
  logic            valid;
  logic            ready;
  tmqe_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/typed_message_queue_engine.sv =====
// Typed message queue engine. Alloc, free and send answer after passing the
// input queue, the execute state and the output register; receive scans the
// pending messages, streams the bytes and shifts the later order entries.
// The back end takes a new item only once it has finished the last one; the
// sequencer and the single-port message memories set the receive pace.
// Reset clears the sequencer, queue tables and send state; no clearing pass is needed.
`default_nettype none
module typed_message_queue_engine #(
  parameter int NUM_QUEUES      = tmqe_pkg::NUM_QUEUES,
  parameter int SLOTS_PER_QUEUE = tmqe_pkg::SLOTS_PER_QUEUE,
  parameter int MSG_BYTES       = tmqe_pkg::MSG_BYTES
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tmqe_req_if.sink      req,
  tmqe_rsp_if.source    rsp
);

  tmqe_req_if item ();

  // front: accept and buffer transactions
  tmqe_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .item (item.source)
  );

  // back: execute and respond
  tmqe_back #(
    .NUM_QUEUES      (NUM_QUEUES),
    .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE),
    .MSG_BYTES       (MSG_BYTES)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .item (item.sink),
    .rsp  (rsp)
  );

endmodule
`default_nettype wire

// ===== sv/tmqe_front.sv =====
// tmqe_front: accepts request transactions into a small queue that feeds
// the execution back end; depends on tmqe_pkg and tmqe_if
`default_nettype none
module tmqe_front (
  input  wire logic     clk,
  input  wire logic     rst,
  tmqe_req_if.sink      req,
  tmqe_req_if.source    item
);

  tmqe_pkg::req_t               fq [tmqe_pkg::FQ_DEPTH];
  logic [tmqe_pkg::FQ_AW-1:0]   wr_ptr;
  logic [tmqe_pkg::FQ_AW-1:0]   rd_ptr;
  logic [tmqe_pkg::FQ_AW:0]     count;
  logic                         push;
  logic                         pop;

  // handshake on both sides
  assign req.ready  = (count != (tmqe_pkg::FQ_AW+1)'(tmqe_pkg::FQ_DEPTH));
  assign item.valid = (count != '0);
  assign item.data  = fq[rd_ptr];
  assign push       = req.valid && req.ready;
  assign pop        = item.valid && item.ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fq[wr_ptr] <= req.data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tmqe_back.sv =====
// tmqe_back: executes alloc, free, send and receive transactions against the
// queue tables and message memories; depends on tmqe_pkg and tmqe_if
`default_nettype none
module tmqe_back #(
  parameter int NUM_QUEUES      = tmqe_pkg::NUM_QUEUES,
  parameter int SLOTS_PER_QUEUE = tmqe_pkg::SLOTS_PER_QUEUE,
  parameter int MSG_BYTES       = tmqe_pkg::MSG_BYTES
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tmqe_req_if.sink      item,
  tmqe_rsp_if.source    rsp
);

  localparam int NS  = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW  = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
  localparam int PCW = $clog2(SLOTS_PER_QUEUE + 1);
  localparam int CW  = $clog2(MSG_BYTES + 1);
  localparam int NSW = (NS > 1) ? $clog2(NS) : 1;
  localparam int PAW = (NS * MSG_BYTES > 1) ? $clog2(NS * MSG_BYTES) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_RD_ORD   = 4'd2;
  localparam logic [3:0] S_RD_TYPE  = 4'd3;
  localparam logic [3:0] S_CMP      = 4'd4;
  localparam logic [3:0] S_BYTE_RD  = 4'd5;
  localparam logic [3:0] S_BYTE_OUT = 4'd6;
  localparam logic [3:0] S_SH_RD    = 4'd7;
  localparam logic [3:0] S_SH_WR    = 4'd8;

  logic [3:0]          state;
  tmqe_pkg::req_t      cur;

  // queue table and slot occupancy
  logic                in_use    [NUM_QUEUES];
  logic signed [31:0]  key_store [NUM_QUEUES];
  logic [PCW-1:0]      pcount    [NUM_QUEUES];
  logic [NS-1:0]       busy;

  // open send
  logic                s_active;
  logic                s_disc;
  logic [2:0]          s_err;
  logic [QW-1:0]       s_queue;
  logic [SW-1:0]       s_slot;
  logic [CW-1:0]       s_count;

  // receive progress
  logic [PCW-1:0]      rp;
  logic [PCW-1:0]      rcnt;
  logic [SW-1:0]       rslot;
  logic [CW-1:0]       rn;
  logic [CW-1:0]       bi;

  // output register
  logic                ov;
  tmqe_pkg::rsp_t      od;
  logic                out_free;
  logic                out_load;
  tmqe_pkg::rsp_t      out_data;

  // memories
  logic signed [31:0]  type_mem  [NS];
  logic [CW-1:0]       len_mem   [NS];
  logic [SW-1:0]       order_mem [NS];
  logic [7:0]          pay_mem   [NS*MSG_BYTES];
  logic signed [31:0]  type_q;
  logic [CW-1:0]       len_q;
  logic [SW-1:0]       ord_q;
  logic [7:0]          pay_q;

  logic                ord_re, ord_we, tl_re, type_we, len_we, pay_re, pay_we;
  logic [NSW-1:0]      ord_raddr, ord_waddr, tl_raddr, type_waddr, len_waddr;
  logic [SW-1:0]       ord_wdata;
  logic [CW-1:0]       len_wdata;
  logic [PAW-1:0]      pay_raddr, pay_waddr;

  // decode of the current transaction
  logic [QW-1:0]       q_cur;
  logic                q_ok;
  logic                in_use_q;
  logic                found_hit, avail_hit;
  logic [QW-1:0]       found_idx, avail_idx;
  logic                free_hit;
  logic [SW-1:0]       free_idx;
  logic                fire;
  logic                snd_start, snd_go, byte_wr, commit, ord_room;
  logic [2:0]          snd_st;
  logic [QW-1:0]       eff_q;
  logic [SW-1:0]       eff_s;
  logic [CW-1:0]       eff_cnt, cnt_new;
  logic [NSW-1:0]      eff_g;
  logic [NSW-1:0]      rbase_g;
  logic                type_hit;
  logic [CW-1:0]       n_take;

  assign out_free   = !ov || rsp.ready;
  assign rsp.valid  = ov;
  assign rsp.data   = od;
  assign item.ready = (state == S_IDLE);
  assign fire       = (state == S_EXEC) && out_free;

  assign q_cur    = QW'(cur.queue_id);
  assign q_ok     = (32'(cur.queue_id) < 32'(NUM_QUEUES));
  assign in_use_q = q_ok && in_use[q_cur];
  assign rbase_g  = NSW'(int'(q_cur) * SLOTS_PER_QUEUE);

  // key match and free queue search, highest index wins
  always_comb begin
    found_hit = 1'b0;
    found_idx = '0;
    avail_hit = 1'b0;
    avail_idx = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (in_use[i] && key_store[i] == cur.key) begin
        found_hit = 1'b1;
        found_idx = QW'(i);
      end
      if (!in_use[i]) begin
        avail_hit = 1'b1;
        avail_idx = QW'(i);
      end
    end
  end

  // lowest idle slot of the addressed queue
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int s = SLOTS_PER_QUEUE - 1; s >= 0; s--) begin
      if (!busy[NSW'(int'(q_cur) * SLOTS_PER_QUEUE + s)]) begin
        free_hit = 1'b1;
        free_idx = SW'(s);
      end
    end
  end

  // send decode
  always_comb begin
    snd_start = !s_disc && !s_active;
    if (s_disc) snd_st = s_err;
    else if (!s_active && !in_use_q) snd_st = tmqe_pkg::ST_NO_ALLOC;
    else if (!s_active && !free_hit) snd_st = tmqe_pkg::ST_NO_SLOT;
    else snd_st = tmqe_pkg::ST_OK;
    snd_go   = !s_disc && (snd_st == tmqe_pkg::ST_OK);
    eff_q    = snd_start ? q_cur : s_queue;
    eff_s    = snd_start ? free_idx : s_slot;
    eff_cnt  = snd_start ? '0 : s_count;
    eff_g    = NSW'(int'(eff_q) * SLOTS_PER_QUEUE + int'(eff_s));
    byte_wr  = snd_go && cur.byte_present && (eff_cnt < CW'(MSG_BYTES));
    cnt_new  = eff_cnt + CW'(byte_wr);
    commit   = snd_go && cur.last_byte;
    ord_room = (pcount[eff_q] < PCW'(SLOTS_PER_QUEUE));
  end

  // receive match and byte count
  assign type_hit = (type_q == cur.msg_type);
  assign n_take   = (int'(len_q) < int'(cur.recv_limit)) ? len_q : CW'(cur.recv_limit);

  // response selection for the output register
  always_comb begin
    out_load = 1'b0;
    out_data = '0;
    out_data.last_result = 1'b1;
    case (state)
      S_EXEC: begin
        out_load = fire && !(cur.req_type == tmqe_pkg::REQ_RECV && in_use_q);
        case (cur.req_type)
          tmqe_pkg::REQ_ALLOC: begin
            if (found_hit) out_data.result_queue = 3'(found_idx);
            else if (avail_hit) out_data.result_queue = 3'(avail_idx);
            else out_data.status = tmqe_pkg::ST_NO_QUEUE;
          end
          tmqe_pkg::REQ_FREE: begin
            if (!q_ok) out_data.status = tmqe_pkg::ST_NO_ALLOC;
          end
          tmqe_pkg::REQ_SEND: out_data.status = snd_st;
          default: begin
            if (!in_use_q) out_data.status = tmqe_pkg::ST_NO_ALLOC;
          end
        endcase
      end
      S_RD_ORD: begin
        out_load        = (rp == rcnt) && out_free;
        out_data.status = tmqe_pkg::ST_NO_MATCH;
      end
      S_CMP: out_load = type_hit && (n_take == '0) && out_free;
      S_BYTE_OUT: begin
        out_load                = out_free;
        out_data.out_byte       = pay_q;
        out_data.out_byte_valid = 1'b1;
        out_data.message_length = 6'(rn);
        out_data.last_result    = ((bi + 1'b1) == rn);
      end
      default: ;
    endcase
  end

  // memory port control
  always_comb begin
    ord_re     = 1'b0;
    ord_raddr  = '0;
    ord_we     = 1'b0;
    ord_waddr  = '0;
    ord_wdata  = '0;
    tl_re      = 1'b0;
    tl_raddr   = rbase_g + NSW'(ord_q);
    type_we    = 1'b0;
    type_waddr = eff_g;
    len_we     = 1'b0;
    len_waddr  = eff_g;
    len_wdata  = cnt_new;
    pay_re     = 1'b0;
    pay_raddr  = PAW'(int'(rbase_g + NSW'(rslot)) * MSG_BYTES + int'(bi));
    pay_we     = 1'b0;
    pay_waddr  = PAW'(int'(eff_g) * MSG_BYTES + int'(eff_cnt));
    case (state)
      S_EXEC: begin
        if (fire && cur.req_type == tmqe_pkg::REQ_SEND) begin
          type_we = snd_go && snd_start;
          pay_we  = byte_wr;
          len_we  = commit;
          ord_we  = commit && ord_room;
          ord_waddr = NSW'(int'(eff_q) * SLOTS_PER_QUEUE + int'(pcount[eff_q]));
          ord_wdata = eff_s;
        end
      end
      S_RD_ORD: begin
        ord_re    = (rp != rcnt);
        ord_raddr = rbase_g + NSW'(rp);
      end
      S_RD_TYPE: tl_re = 1'b1;
      S_BYTE_RD: pay_re = 1'b1;
      S_SH_RD: begin
        ord_re    = ((rp + 1'b1) < rcnt);
        ord_raddr = rbase_g + NSW'(rp + 1'b1);
      end
      S_SH_WR: begin
        ord_we    = 1'b1;
        ord_waddr = rbase_g + NSW'(rp);
        ord_wdata = ord_q;
      end
      default: ;
    endcase
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    if (ord_we) order_mem[ord_waddr] <= ord_wdata;
    if (ord_re) ord_q <= order_mem[ord_raddr];
    if (type_we) type_mem[type_waddr] <= cur.msg_type;
    if (len_we) len_mem[len_waddr] <= len_wdata;
    if (tl_re) begin
      type_q <= type_mem[tl_raddr];
      len_q  <= len_mem[tl_raddr];
    end
    if (pay_we) pay_mem[pay_waddr] <= cur.data_byte;
    if (pay_re) pay_q <= pay_mem[pay_raddr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_load) begin
      ov <= 1'b1;
      od <= out_data;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  // sequencer and tables
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      busy     <= '0;
      s_active <= 1'b0;
      s_disc   <= 1'b0;
      s_err    <= tmqe_pkg::ST_OK;
      s_queue  <= '0;
      s_slot   <= '0;
      s_count  <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        in_use[i]    <= 1'b0;
        key_store[i] <= '0;
        pcount[i]    <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            cur   <= item.data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state <= (cur.req_type == tmqe_pkg::REQ_RECV && in_use_q) ? S_RD_ORD : S_IDLE;
            case (cur.req_type)
              tmqe_pkg::REQ_ALLOC: begin
                if (!found_hit && avail_hit) begin
                  in_use[avail_idx]    <= 1'b1;
                  key_store[avail_idx] <= cur.key;
                end
              end
              tmqe_pkg::REQ_FREE: begin
                if (q_ok) begin
                  in_use[q_cur]    <= 1'b0;
                  key_store[q_cur] <= '0;
                  pcount[q_cur]    <= '0;
                  for (int s = 0; s < SLOTS_PER_QUEUE; s++) begin
                    busy[NSW'(int'(q_cur) * SLOTS_PER_QUEUE + s)] <= 1'b0;
                  end
                  if (s_active && s_queue == q_cur) begin
                    s_active <= 1'b0;
                    s_disc   <= 1'b1;
                    s_err    <= tmqe_pkg::ST_NO_ALLOC;
                  end
                end
              end
              tmqe_pkg::REQ_SEND: begin
                if (s_disc) begin
                  if (cur.last_byte) s_disc <= 1'b0;
                end else if (snd_st != tmqe_pkg::ST_OK) begin
                  if (!cur.last_byte) begin
                    s_disc <= 1'b1;
                    s_err  <= snd_st;
                  end
                end else begin
                  if (snd_start) begin
                    busy[eff_g] <= 1'b1;
                    s_queue     <= eff_q;
                    s_slot      <= eff_s;
                  end
                  s_count  <= cnt_new;
                  s_active <= !cur.last_byte;
                  if (commit && ord_room) pcount[eff_q] <= pcount[eff_q] + 1'b1;
                end
              end
              default: begin
                if (in_use_q) begin
                  rp   <= '0;
                  rcnt <= pcount[q_cur];
                end
              end
            endcase
          end
        end
        S_RD_ORD: begin
          if (rp != rcnt) begin
            state <= S_RD_TYPE;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_RD_TYPE: begin
          rslot <= ord_q;
          state <= S_CMP;
        end
        S_CMP: begin
          if (!type_hit) begin
            rp    <= rp + 1'b1;
            state <= S_RD_ORD;
          end else if (n_take != '0) begin
            rn    <= n_take;
            bi    <= '0;
            state <= S_BYTE_RD;
          end else if (out_free) begin
            state <= S_SH_RD;
          end
        end
        S_BYTE_RD: state <= S_BYTE_OUT;
        S_BYTE_OUT: begin
          if (out_free) begin
            bi    <= bi + 1'b1;
            state <= ((bi + 1'b1) == rn) ? S_SH_RD : S_BYTE_RD;
          end
        end
        S_SH_RD: begin
          if ((rp + 1'b1) < rcnt) begin
            state <= S_SH_WR;
          end else begin
            pcount[q_cur]           <= rcnt - 1'b1;
            busy[rbase_g + NSW'(rslot)] <= 1'b0;
            state                   <= S_IDLE;
          end
        end
        S_SH_WR: begin
          rp    <= rp + 1'b1;
          state <= S_SH_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an open send and a discard run never coexist
  a_send_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_active && s_disc)) else $error("send open while discarding");

  // error responses always end the transaction
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (ov && od.status != tmqe_pkg::ST_OK) |-> od.last_result)
    else $error("error response not final");

  // a response without payload reports zero length
  a_nobyte_len: assert property (@(posedge clk) disable iff (rst)
    (ov && !od.out_byte_valid) |-> (od.message_length == 6'd0))
    else $error("length without payload");

  // a new item is taken only after the previous one completed
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (state == S_EXEC))
    else $error("item taken outside idle");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// testbench: self-checking bench for typed_message_queue_engine, with a mailbox
// predictor in a scoreboard class and randomized, bursty request traffic
// depends on tmqe_pkg, tmqe_if and the engine rtl
`default_nettype none
module testbench;

  // mailbox predictor and expected response store
  class mailbox_scoreboard;
    bit         in_use [tmqe_pkg::NUM_QUEUES];
    bit [31:0]  qkey [tmqe_pkg::NUM_QUEUES];
    bit         busy [tmqe_pkg::NUM_QUEUES][tmqe_pkg::SLOTS_PER_QUEUE];
    bit [31:0]  mtype [tmqe_pkg::NUM_QUEUES][tmqe_pkg::SLOTS_PER_QUEUE];
    int         mlen [tmqe_pkg::NUM_QUEUES][tmqe_pkg::SLOTS_PER_QUEUE];
    bit [7:0]   payload [tmqe_pkg::NUM_QUEUES][tmqe_pkg::SLOTS_PER_QUEUE][tmqe_pkg::MSG_BYTES];
    int         order [tmqe_pkg::NUM_QUEUES][$];
    bit         tx_open, tx_drop;
    int         tx_q, tx_s, tx_cnt;
    bit [2:0]   tx_err;
    tmqe_pkg::rsp_t pending_rsp [$];
    int         mismatches;

    function void push(bit [2:0] st, bit [2:0] rq, bit [7:0] b, bit v, bit [5:0] n,
                       bit lst);
      tmqe_pkg::rsp_t r;
      r.status = st; r.result_queue = rq; r.out_byte = b;
      r.out_byte_valid = v; r.message_length = n; r.last_result = lst;
      pending_rsp.push_back(r);
    endfunction

    function void note_request(tmqe_pkg::req_t t);
      int found, avail, s, n;
      bit [2:0] st;
      found = -1; avail = -1; st = tmqe_pkg::ST_OK;
      case (t.req_type)
        tmqe_pkg::REQ_ALLOC: begin
          for (int i = 0; i < tmqe_pkg::NUM_QUEUES; i++) begin
            if (in_use[i] && qkey[i] == t.key) found = i;
            if (!in_use[i]) avail = i;
          end
          if (found >= 0) push(tmqe_pkg::ST_OK, 3'(found), 0, 0, 0, 1);
          else if (avail < 0) push(tmqe_pkg::ST_NO_QUEUE, 0, 0, 0, 0, 1);
          else begin
            in_use[avail] = 1; qkey[avail] = t.key;
            push(tmqe_pkg::ST_OK, 3'(avail), 0, 0, 0, 1);
          end
        end
        tmqe_pkg::REQ_FREE: begin
          in_use[t.queue_id] = 0; qkey[t.queue_id] = 0;
          order[t.queue_id].delete();
          for (int i = 0; i < tmqe_pkg::SLOTS_PER_QUEUE; i++) busy[t.queue_id][i] = 0;
          if (tx_open && tx_q == t.queue_id) begin
            tx_open = 0; tx_drop = 1; tx_err = tmqe_pkg::ST_NO_ALLOC;
          end
          push(tmqe_pkg::ST_OK, 0, 0, 0, 0, 1);
        end
        tmqe_pkg::REQ_SEND: begin
          if (tx_drop) begin
            st = tx_err;
            if (t.last_byte) tx_drop = 0;
            push(st, 0, 0, 0, 0, 1);
            return;
          end
          if (!tx_open) begin
            if (!in_use[t.queue_id]) st = tmqe_pkg::ST_NO_ALLOC;
            else begin
              s = -1;
              for (int i = tmqe_pkg::SLOTS_PER_QUEUE - 1; i >= 0; i--)
                if (!busy[t.queue_id][i]) s = i;
              if (s < 0) st = tmqe_pkg::ST_NO_SLOT;
              else begin
                busy[t.queue_id][s] = 1; mtype[t.queue_id][s] = t.msg_type;
                tx_open = 1; tx_q = t.queue_id; tx_s = s; tx_cnt = 0;
              end
            end
            if (st != tmqe_pkg::ST_OK) begin
              if (!t.last_byte) begin tx_drop = 1; tx_err = st; end
              push(st, 0, 0, 0, 0, 1);
              return;
            end
          end
          if (t.byte_present && tx_cnt < tmqe_pkg::MSG_BYTES) begin
            payload[tx_q][tx_s][tx_cnt] = t.data_byte;
            tx_cnt++;
          end
          if (t.last_byte) begin
            mlen[tx_q][tx_s] = tx_cnt;
            if (order[tx_q].size() < tmqe_pkg::SLOTS_PER_QUEUE) order[tx_q].push_back(tx_s);
            tx_open = 0;
          end
          push(tmqe_pkg::ST_OK, 0, 0, 0, 0, 1);
        end
        default: begin
          if (!in_use[t.queue_id]) begin
            push(tmqe_pkg::ST_NO_ALLOC, 0, 0, 0, 0, 1);
            return;
          end
          found = -1;
          foreach (order[t.queue_id][p])
            if (found < 0 && mtype[t.queue_id][order[t.queue_id][p]] == t.msg_type)
              found = p;
          if (found < 0) begin push(tmqe_pkg::ST_NO_MATCH, 0, 0, 0, 0, 1); return; end
          s = order[t.queue_id][found];
          n = mlen[t.queue_id][s];
          if (n > t.recv_limit) n = t.recv_limit;
          if (n == 0) push(tmqe_pkg::ST_OK, 0, 0, 0, 0, 1);
          for (int i = 0; i < n; i++)
            push(tmqe_pkg::ST_OK, 0, payload[t.queue_id][s][i], 1, 6'(n), i + 1 == n);
          order[t.queue_id].delete(found);
          busy[t.queue_id][s] = 0;
        end
      endcase
    endfunction

    task check_response(tmqe_pkg::rsp_t got);
      tmqe_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with nothing expected", 0, got);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status != want.status) report_mismatch("status", want.status, got.status);
      if (got.result_queue != want.result_queue)
        report_mismatch("result_queue", want.result_queue, got.result_queue);
      if (got.out_byte != want.out_byte)
        report_mismatch("out_byte", want.out_byte, got.out_byte);
      if (got.out_byte_valid != want.out_byte_valid)
        report_mismatch("out_byte_valid", want.out_byte_valid, got.out_byte_valid);
      if (got.message_length != want.message_length)
        report_mismatch("message_length", want.message_length, got.message_length);
      if (got.last_result != want.last_result)
        report_mismatch("last_result", want.last_result, got.last_result);
    endtask

    task report_mismatch(string what, longint want, longint got);
      $display("mismatch %s: expected %0h got %0h", what, want, got);
      mismatches++;
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  tmqe_req_if req_ch ();
  tmqe_rsp_if rsp_ch ();
  mailbox_scoreboard sb = new();
  bit   hold_rx = 0;
  int   idle_cycles = 0;
  bit   timed_out = 0;
  bit   main_done = 0;
  bit [31:0] live_keys [4];
  bit [31:0] live_types [4];

  typed_message_queue_engine u_top (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch));

  always #1 clk = ~clk;

  initial begin
    req_ch.valid = 0;
    req_ch.data = '0;
    rsp_ch.ready = 0;
  end

  // accepted transaction monitor and idle watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (!req_ch.valid && sb.pending_rsp.size() == 0) || hold_rx)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 4000) timed_out = 1;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_rx) rsp_ch.ready <= 0;
    else rsp_ch.ready <= ($urandom_range(0, 9) < 7);
  end

  task automatic send_request(tmqe_pkg::req_t t);
    req_ch.valid <= 1;
    req_ch.data <= t;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic gap();
    req_ch.valid <= 0;
    repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  task automatic issue(tmqe_pkg::req_t t);
    send_request(t);
    if ($urandom_range(0, 5) == 0) gap();
  endtask

  function automatic tmqe_pkg::req_t blank(bit [1:0] op);
    tmqe_pkg::req_t t;
    t = '0;
    t.req_type = op;
    t.key = $urandom; t.msg_type = $urandom; t.data_byte = 8'($urandom);
    t.queue_id = 3'($urandom); t.recv_limit = 6'($urandom_range(0, 32));
    return t;
  endfunction

  task automatic drain();
    req_ch.valid <= 0;
    while (sb.pending_rsp.size() != 0 && !timed_out) @(negedge clk);
  endtask

  // one message: every item carries queue and type; a byte on all but the last, which may carry one
  task automatic send_message(int q, bit [31:0] mt, int nbytes);
    tmqe_pkg::req_t t;
    for (int i = 0; i <= nbytes; i++) begin
      t = blank(tmqe_pkg::REQ_SEND);
      t.queue_id = 3'(q); t.msg_type = mt;
      t.byte_present = (i < nbytes) ? 1'b1 : ($urandom_range(0, 1) == 0);
      t.last_byte = (i == nbytes);
      issue(t);
    end
  endtask

  task automatic directed();
    tmqe_pkg::req_t t;
    t = blank(tmqe_pkg::REQ_RECV); t.queue_id = 0; issue(t);      // receive unallocated
    t = blank(tmqe_pkg::REQ_SEND); t.queue_id = 3; t.last_byte = 0; issue(t);
    t = blank(tmqe_pkg::REQ_SEND); t.last_byte = 1; issue(t);     // discarded tail
    t = blank(tmqe_pkg::REQ_ALLOC); t.key = 32'h8000_0000; issue(t);
    t = blank(tmqe_pkg::REQ_ALLOC); t.key = 32'h7fff_ffff; issue(t);
    t = blank(tmqe_pkg::REQ_ALLOC); t.key = 32'h8000_0000; issue(t);  // key hit
    send_message(7, 32'hffff_ffff, 0);                              // empty message
    send_message(7, 32'h0, 34);                                     // overflow
    t = blank(tmqe_pkg::REQ_RECV); t.queue_id = 7; t.msg_type = 32'h1; issue(t);
    t = blank(tmqe_pkg::REQ_RECV); t.queue_id = 7; t.msg_type = 32'h0;
    t.recv_limit = 32; issue(t);
    t = blank(tmqe_pkg::REQ_RECV); t.queue_id = 7; t.msg_type = 32'hffff_ffff; issue(t);
    for (int i = 0; i < 8; i++) begin
      t = blank(tmqe_pkg::REQ_ALLOC); t.key = i + 100; issue(t);  // fill table
    end
    send_message(6, 32'h5, 1);
    t = blank(tmqe_pkg::REQ_SEND); t.queue_id = 6; t.last_byte = 0; t.byte_present = 1;
    issue(t);
    t = blank(tmqe_pkg::REQ_FREE); t.queue_id = 6; issue(t);      // free with open send
    t = blank(tmqe_pkg::REQ_SEND); t.last_byte = 1; issue(t);
    for (int i = 0; i < 8; i++) begin
      t = blank(tmqe_pkg::REQ_FREE); t.queue_id = 3'(i); issue(t);
    end
    drain();
  endtask

  task automatic random_item();
    tmqe_pkg::req_t t;
    int q, r;
    r = $urandom_range(0, 99);
    q = $urandom_range(0, 7);
    if (r < 12) begin
      t = blank(tmqe_pkg::REQ_ALLOC);
      if ($urandom_range(0, 3) != 0) t.key = live_keys[$urandom_range(0, 3)];
      issue(t);
    end else if (r < 17) begin
      t = blank(tmqe_pkg::REQ_FREE); issue(t);
    end else if (r < 55) begin
      if ($urandom_range(0, 3) == 0) send_message(q, live_types[$urandom_range(0, 3)],
                                                  $urandom_range(0, 34));
      else send_message(q, live_types[$urandom_range(0, 3)], $urandom_range(0, 4));
    end else if (r < 60) begin
      t = blank(tmqe_pkg::REQ_SEND);
      t.byte_present = 1'($urandom); t.last_byte = 1'($urandom);
      issue(t);
    end else begin
      t = blank(tmqe_pkg::REQ_RECV);
      if ($urandom_range(0, 4) != 0) t.msg_type = live_types[$urandom_range(0, 3)];
      if ($urandom_range(0, 4) == 0) t.recv_limit = 0;
      issue(t);
    end
  endtask

  initial begin
    int sent;
    for (int i = 0; i < 4; i++) begin
      live_keys[i] = $urandom; live_types[i] = $urandom;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    directed();
    for (int i = 0; i < 8; i++) random_item();
    // long receiver hold while requests keep coming
    hold_rx = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_rx = 0;
      end
      for (int i = 0; i < 12; i++) random_item();
    join
    drain();
    sent = 0;
    while (sent < 95 && !timed_out) begin
      repeat ($urandom_range(1, 12)) if (!timed_out) begin random_item(); sent++; end
      if ($urandom_range(0, 2) == 0) gap();
    end
    drain();
    repeat (200) @(negedge clk);
    main_done = 1;
  end

  // end of run
  initial begin
    wait (rst == 0);
    forever begin
      @(posedge clk);
      if (timed_out) begin
        $display("testbench failed");
        $finish;
      end
      if (main_done) begin
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
